/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros for the checker file rtmp_chk
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property sampled on the rising clock, off while reset is low
`define RTMP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// condition in this cycle implies a consequence in the next cycle
`define RTMP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/rtmp_pkg.sv */
// ----------------------------------------------------------------------------
// rtmp_pkg
// types, widths and constant tables for the recurrence term matrix power block
// ----------------------------------------------------------------------------
`default_nettype none

package rtmp_pkg;

    localparam int TERM_INDEX_W = 31;
    localparam int TERM_VALUE_W = 11;
    localparam int S_TDATA_W    = 32;
    localparam int M_TDATA_W    = 16;
    localparam int ADDR_W       = 6;   // slot(2) row(2) col(2)
    localparam int SEED_LAST    = 4;   // highest index answered from the seed table

    // controller to datapath commands
    typedef struct packed {
        logic              init_we;
        logic [4:0]        init_idx;
        logic              issue;
        logic [ADDR_W-1:0] addr_a;
        logic [ADDR_W-1:0] addr_b;
        logic              use_seed;
        logic [1:0]        seed_k;
        logic              first;
        logic              last;
        logic              to_out;
        logic [ADDR_W-1:0] dest;
        logic              small_ld;
        logic [2:0]        small_idx;
        logic              out_ld;
    } rtmp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic busy;
    } rtmp_sts_t;

    // seed terms f(0..4)
    function automatic logic [3:0] seed_term(input logic [2:0] idx);
        logic [3:0] v;
        case (idx)
            3'd0:    v = 4'd0;
            3'd1:    v = 4'd2;
            3'd2:    v = 4'd4;
            3'd3:    v = 4'd6;
            3'd4:    v = 4'd9;
            default: v = 4'd0;
        endcase
        return v;
    endfunction

    // seeds f(1..4) used in the final dot product
    function automatic logic [3:0] dot_seed(input logic [1:0] k);
        logic [3:0] v;
        case (k)
            2'd0:    v = 4'd2;
            2'd1:    v = 4'd4;
            2'd2:    v = 4'd6;
            2'd3:    v = 4'd9;
            default: v = 4'd0;
        endcase
        return v;
    endfunction

    // start matrices: idx[4]=0 identity, idx[4]=1 companion; idx[3:2] row, idx[1:0] col
    function automatic logic init_bit(input logic [4:0] idx);
        logic [1:0] r;
        logic [1:0] c;
        logic       v;
        r = idx[3:2];
        c = idx[1:0];
        if (!idx[4])
        begin
            v = (r == c);
        end
        else if (r == 2'd3)
        begin
            v = (c == 2'd0) || (c == 2'd1) || (c == 2'd3);
        end
        else
        begin
            v = (c == r + 2'd1);
        end
        return v;
    endfunction

endpackage

`default_nettype wire

/* hdl/recurrence_term_matrix_power_mod.sv */
// ----------------------------------------------------------------------------
// recurrence_term_matrix_power_mod
// term n of f(n)=f(n-1)+f(n-3)+f(n-4) mod MODULUS by 4x4 matrix power
// ----------------------------------------------------------------------------
//  channel  | dir | signals                  | word
//  ---------+-----+--------------------------+-------------------------------
//  s_       | in  | s_tvalid/s_tready/s_tdata | term_index [30:0], zero pad
//  m_       | out | m_tvalid/m_tready/m_tdata | term_value [10:0], zero pad
//
//  one word at a time; index up to 4: seed to the result register on accept,
//    then to the output register once free; otherwise: load the start matrices,
//    then per matrix product a pick step, 64 multiply-accumulates on the one
//    shared unit and a drain until the pipeline is empty, one product per set
//    bit of n-4 and one squaring per bit above the lowest, then the final dot
//    product and output load; worst case at 31 index bits is 60 products
//  a finished word waits in the output register while the next word is taken;
//    the next result is held back until that word is taken
//  reset is asynchronous and active low; it clears control state only
// ----------------------------------------------------------------------------
`default_nettype none

module recurrence_term_matrix_power_mod #(
    parameter int MODULUS    = 2005,
    parameter int INDEX_BITS = 31
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [rtmp_pkg::S_TDATA_W-1:0]   s_tdata,   // [30:0] term_index
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [rtmp_pkg::M_TDATA_W-1:0]        m_tdata    // [10:0] term_value
);

    rtmp_pkg::rtmp_cmd_t cmd;
    rtmp_pkg::rtmp_sts_t sts;
    logic [rtmp_pkg::TERM_VALUE_W-1:0] term_value;

    // sequencer: start load, square-and-multiply steps, final row dot seeds
    rtmp_ctrl #(
        .INDEX_BITS (INDEX_BITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .term_index (s_tdata[rtmp_pkg::TERM_INDEX_W-1:0]),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .cmd        (cmd),
        .sts        (sts)
    );

    // matrix store and modular multiply-accumulate pipeline
    rtmp_dpath #(
        .MODULUS (MODULUS)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .term_value (term_value)
    );

    // pad the result word to whole bytes
    assign m_tdata = rtmp_pkg::M_TDATA_W'(term_value);

endmodule

`default_nettype wire

/* hdl/rtmp_dpath.sv */
// ----------------------------------------------------------------------------
// rtmp_dpath
// matrix store and pipelined modular multiply-accumulate unit
// ----------------------------------------------------------------------------
`default_nettype none

module rtmp_dpath #(
    parameter int MODULUS = 2005
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire rtmp_pkg::rtmp_cmd_t               cmd,
    output rtmp_pkg::rtmp_sts_t                    sts,
    output logic [rtmp_pkg::TERM_VALUE_W-1:0]      term_value
);

    localparam int MW    = $clog2(MODULUS);
    localparam int PW    = 2 * MW;
    localparam int TW    = 3 * MW + 1;
    localparam int DEPTH = 1 << rtmp_pkg::ADDR_W;
    localparam logic [MW:0] MOD_W = (MW+1)'(MODULUS);
    // floor(2^(2*MW) / MODULUS) for the reciprocal estimate of the quotient
    localparam logic [MW:0] RECIP = (MW+1)'((64'd1 << (2 * MW)) / MODULUS);

    typedef struct packed {
        logic                        valid;
        logic                        first;
        logic                        last;
        logic                        to_out;
        logic [rtmp_pkg::ADDR_W-1:0] dest;
    } tag_t;

    logic [MW-1:0] mem [0:DEPTH-1];

    logic [MW-1:0] rd_a_reg;
    logic [MW-1:0] rd_b_reg;
    logic          use_seed_reg;
    logic [1:0]    seed_k_reg;
    tag_t          tag1_reg, tag2_reg, tag3_reg, tag4_reg, tag5_reg;

    logic [PW-1:0] p2_reg, p3_reg, p4_reg;
    logic [TW-1:0] t3_reg;
    logic [PW-1:0] qm4_reg;
    logic [MW-1:0] r5_reg;
    logic [MW-1:0] acc_reg;
    logic [MW-1:0] res_reg;

    logic [MW-1:0]               opb;
    logic [MW-1:0]               q;
    logic [PW-1:0]               diff;
    logic [MW:0]                 rem;
    logic [MW:0]                 sum;
    logic [MW-1:0]               acc_next;
    logic                        we;
    logic [rtmp_pkg::ADDR_W-1:0] wa;
    logic [MW-1:0]               wd;

    tag_t tag0;

    always_comb
    begin
        tag0.valid  = cmd.issue;
        tag0.first  = cmd.first;
        tag0.last   = cmd.last;
        tag0.to_out = cmd.to_out;
        tag0.dest   = cmd.dest;
    end

    assign opb  = use_seed_reg ? MW'(rtmp_pkg::dot_seed(seed_k_reg)) : rd_b_reg;
    assign q    = t3_reg[PW +: MW];
    assign diff = p4_reg - qm4_reg;
    assign rem  = diff[MW:0];
    assign sum  = (tag5_reg.first ? (MW+1)'(0) : {1'b0, acc_reg}) + {1'b0, r5_reg};
    assign acc_next = (sum >= MOD_W) ? MW'(sum - MOD_W) : MW'(sum);

    assign we = cmd.init_we || (tag5_reg.valid && tag5_reg.last && !tag5_reg.to_out);
    assign wa = cmd.init_we ? {1'b0, cmd.init_idx} : tag5_reg.dest;
    assign wd = cmd.init_we ? MW'(rtmp_pkg::init_bit(cmd.init_idx)) : acc_next;

    // matrix store: two read ports, one write port
    always_ff @(posedge clk)
    begin
        rd_a_reg <= mem[cmd.addr_a];
        rd_b_reg <= mem[cmd.addr_b];
        if (we)
        begin
            mem[wa] <= wd;
        end
    end

    // tags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
            tag4_reg <= '0;
            tag5_reg <= '0;
        end
        else
        begin
            tag1_reg <= tag0;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
            tag4_reg <= tag3_reg;
            tag5_reg <= tag4_reg;
        end
    end

    // multiply, quotient estimate, remainder, accumulate
    always_ff @(posedge clk)
    begin
        use_seed_reg <= cmd.use_seed;
        seed_k_reg   <= cmd.seed_k;
        p2_reg       <= PW'(rd_a_reg) * PW'(opb);
        t3_reg       <= TW'(p2_reg) * TW'(RECIP);
        p3_reg       <= p2_reg;
        qm4_reg      <= PW'(q) * PW'(MOD_W);
        p4_reg       <= p3_reg;
        r5_reg       <= (rem >= MOD_W) ? MW'(rem - MOD_W) : MW'(rem);
        if (tag5_reg.valid)
        begin
            acc_reg <= acc_next;
        end
        if (cmd.small_ld)
        begin
            res_reg <= MW'(rtmp_pkg::seed_term(cmd.small_idx));
        end
        else if (tag5_reg.valid && tag5_reg.last && tag5_reg.to_out)
        begin
            res_reg <= acc_next;
        end
        if (cmd.out_ld)
        begin
            term_value <= rtmp_pkg::TERM_VALUE_W'(res_reg);
        end
    end

    assign sts.busy = tag1_reg.valid || tag2_reg.valid || tag3_reg.valid
                   || tag4_reg.valid || tag5_reg.valid;

endmodule

`default_nettype wire

/* hdl/rtmp_ctrl.sv */
// ----------------------------------------------------------------------------
// rtmp_ctrl
// sequencer for square-and-multiply over the matrix store
// ----------------------------------------------------------------------------
`default_nettype none

module rtmp_ctrl #(
    parameter int INDEX_BITS = 31
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [rtmp_pkg::TERM_INDEX_W-1:0]   term_index,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output rtmp_pkg::rtmp_cmd_t                      cmd,
    input  wire rtmp_pkg::rtmp_sts_t                 sts
);

    localparam int EW = INDEX_BITS;
    localparam logic [1:0] SLOT_ID   = 2'd0;  // identity at start
    localparam logic [1:0] SLOT_COMP = 2'd1;  // companion at start
    localparam logic [1:0] SLOT_FREE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE, ST_INIT, ST_PICK, ST_PROD, ST_DRAIN, ST_FINAL, ST_FDRAIN, ST_OUT
    } state_t;

    state_t        state_reg;
    logic [5:0]    cnt_reg;
    logic [EW-1:0] ex_reg;
    logic          sq_reg;
    logic [1:0]    acc_slot_reg;
    logic [1:0]    base_slot_reg;
    logic [1:0]    free_slot_reg;
    logic          m_tvalid_reg;

    logic [EW-1:0] n_val;
    logic          n_small;
    logic          out_free;
    logic [1:0]    ci, cj, ck;

    assign n_val    = EW'(term_index);
    assign n_small  = (n_val <= EW'(rtmp_pkg::SEED_LAST));
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign ci = cnt_reg[5:4];
    assign cj = cnt_reg[3:2];
    assign ck = cnt_reg[1:0];

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.small_ld  = s_tvalid && n_small;
                cmd.small_idx = n_val[2:0];
            end
            ST_INIT:
            begin
                cmd.init_we  = 1'b1;
                cmd.init_idx = cnt_reg[4:0];
            end
            ST_PROD:
            begin
                cmd.issue  = 1'b1;
                cmd.addr_a = {(sq_reg ? base_slot_reg : acc_slot_reg), ci, ck};
                cmd.addr_b = {base_slot_reg, ck, cj};
                cmd.dest   = {free_slot_reg, ci, cj};
                cmd.first  = (ck == 2'd0);
                cmd.last   = (ck == 2'd3);
            end
            ST_FINAL:
            begin
                cmd.issue    = 1'b1;
                cmd.addr_a   = {acc_slot_reg, 2'd3, ck};
                cmd.use_seed = 1'b1;
                cmd.seed_k   = ck;
                cmd.to_out   = 1'b1;
                cmd.first    = (ck == 2'd0);
                cmd.last     = (ck == 2'd3);
            end
            ST_OUT:
            begin
                cmd.out_ld = out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            ex_reg        <= '0;
            sq_reg        <= 1'b0;
            acc_slot_reg  <= SLOT_ID;
            base_slot_reg <= SLOT_COMP;
            free_slot_reg <= SLOT_FREE;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_OUT && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    cnt_reg <= '0;
                    if (s_tvalid)
                    begin
                        if (n_small)
                        begin
                            state_reg <= ST_OUT;
                        end
                        else
                        begin
                            ex_reg    <= n_val - EW'(rtmp_pkg::SEED_LAST);
                            state_reg <= ST_INIT;
                        end
                    end
                end
                ST_INIT:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg[4:0] == 5'd31)
                    begin
                        acc_slot_reg  <= SLOT_ID;
                        base_slot_reg <= SLOT_COMP;
                        free_slot_reg <= SLOT_FREE;
                        state_reg     <= ST_PICK;
                    end
                end
                ST_PICK:
                begin
                    cnt_reg <= '0;
                    if (ex_reg == '0)
                    begin
                        state_reg <= ST_FINAL;
                    end
                    else
                    begin
                        sq_reg    <= !ex_reg[0];
                        state_reg <= ST_PROD;
                    end
                end
                ST_PROD:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd63)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    if (!sts.busy)
                    begin
                        if (sq_reg)
                        begin
                            base_slot_reg <= free_slot_reg;
                            free_slot_reg <= base_slot_reg;
                            ex_reg        <= ex_reg >> 1;
                        end
                        else
                        begin
                            acc_slot_reg  <= free_slot_reg;
                            free_slot_reg <= acc_slot_reg;
                            ex_reg[0]     <= 1'b0;
                        end
                        state_reg <= ST_PICK;
                    end
                end
                ST_FINAL:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (ck == 2'd3)
                    begin
                        state_reg <= ST_FDRAIN;
                    end
                end
                ST_FDRAIN:
                begin
                    if (!sts.busy)
                    begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* hdl/rtmp_chk.sv */
// ----------------------------------------------------------------------------
// rtmp_chk
// port-level checks for the recurrence term block
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rtmp_chk #(
    parameter int MODULUS = 2005
) (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic [rtmp_pkg::S_TDATA_W-1:0] s_tdata,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [rtmp_pkg::M_TDATA_W-1:0] m_tdata
);

    // a stalled result word stays offered
    `RTMP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result word dropped")

    // a stalled result word keeps its value
    `RTMP_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata), "result word changed")

    // a waiting index word keeps its value
    `RTMP_ASSERT_NEXT(a_in_stable, s_tvalid && !s_tready, $stable(s_tdata), "index word changed")

    // one index in work at a time: the input closes right after a take
    `RTMP_ASSERT_NEXT(a_in_busy, s_tvalid && s_tready, !s_tready, "input open while busy")

    // results are reduced and padding bits are zero
    `RTMP_ASSERT(a_out_range, !m_tvalid || ((m_tdata[15:11] == 5'd0)
        && ((MODULUS > 2048) || (m_tdata[10:0] < MODULUS))), "result out of range")

endmodule

bind recurrence_term_matrix_power_mod rtmp_chk #(
    .MODULUS (MODULUS)
) u_rtmp_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

/* tb/recurrence_term_matrix_power_mod_tb.sv */
// ----------------------------------------------------------------------------
// recurrence_term_matrix_power_mod_tb
// streams term indices into the block and checks each returned term against
// a matrix power computed here, with random gaps on both sides
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module recurrence_term_matrix_power_mod_tb;

    localparam int TERM_MOD   = 2005;
    localparam int HALF_CLK   = 6;      // 12 ns period
    localparam int TAIL_WAIT  = 60;     // quiet cycles after the last term
    localparam int RAND_WORDS = 120;

    // one index waiting to be sent; drain_first holds it until all terms are back
    typedef struct packed {
        logic [rtmp_pkg::TERM_INDEX_W-1:0] index;
        logic                              drain_first;
    } index_item_t;

    // one term owed by the block, with the index that asked for it
    typedef struct packed {
        logic [rtmp_pkg::TERM_INDEX_W-1:0] index;
        logic [rtmp_pkg::TERM_VALUE_W-1:0] value;
    } term_owed_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [rtmp_pkg::S_TDATA_W-1:0] s_tdata  = '0;   // [30:0] term_index, [31] zero pad
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [rtmp_pkg::M_TDATA_W-1:0] m_tdata;   // [10:0] term_value, [15:11] zero pad

    index_item_t index_q [$];
    term_owed_t  term_expected_q [$];

    int mismatch_count = 0;
    int words_sent     = 0;
    int terms_checked  = 0;
    int seed_words     = 0;
    int wide_words     = 0;

    // driver and monitor private state, written only in their own blocks
    int          send_wait = 0;
    bit          send_calm = 1'b0;
    index_item_t next_item;
    int          take_wait = 0;
    bit          take_calm = 1'b0;
    term_owed_t  owed;

    recurrence_term_matrix_power_mod #(
        .MODULUS    (TERM_MOD),
        .INDEX_BITS (rtmp_pkg::TERM_INDEX_W)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #HALF_CLK clk = 1'b1;
        #HALF_CLK clk = 1'b0;
    end

    // term n of f(n)=f(n-1)+f(n-3)+f(n-4) mod TERM_MOD, seeds 0,2,4,6,9
    function automatic logic [rtmp_pkg::TERM_VALUE_W-1:0] term_mod_of(
        input logic [rtmp_pkg::TERM_INDEX_W-1:0] n);
        longint unsigned                   seeds [5];
        longint unsigned                   base_m [4][4];
        longint unsigned                   prod_m [4][4];
        longint unsigned                   next_base [4][4];
        longint unsigned                   next_prod [4][4];
        longint unsigned                   sq_sum;
        longint unsigned                   mul_sum;
        longint unsigned                   term;
        logic [rtmp_pkg::TERM_INDEX_W-1:0] ex;
        int                                i;
        int                                j;
        int                                k;
        seeds[0] = 0;
        seeds[1] = 2;
        seeds[2] = 4;
        seeds[3] = 6;
        seeds[4] = 9;
        // small index: seed straight out, no reduction
        if (n <= rtmp_pkg::SEED_LAST)
        begin
            term = seeds[n[2:0]];
            return term[rtmp_pkg::TERM_VALUE_W-1:0];
        end
        // companion matrix in base_m, identity in prod_m
        for (i = 0; i < 4; i++)
        begin
            for (j = 0; j < 4; j++)
            begin
                base_m[i][j] = (j == i + 1) ? 1 : 0;
                prod_m[i][j] = (j == i) ? 1 : 0;
            end
        end
        base_m[3][0] = 1;
        base_m[3][1] = 1;
        base_m[3][3] = 1;
        // square-and-multiply over n-4, each entry reduced after its dot product
        ex = n - rtmp_pkg::TERM_INDEX_W'(rtmp_pkg::SEED_LAST);
        while (ex != 0)
        begin
            for (i = 0; i < 4; i++)
            begin
                for (j = 0; j < 4; j++)
                begin
                    mul_sum = 0;
                    sq_sum  = 0;
                    for (k = 0; k < 4; k++)
                    begin
                        mul_sum += prod_m[i][k] * base_m[k][j];
                        sq_sum  += base_m[i][k] * base_m[k][j];
                    end
                    next_prod[i][j] = mul_sum % TERM_MOD;
                    next_base[i][j] = sq_sum % TERM_MOD;
                end
            end
            for (i = 0; i < 4; i++)
            begin
                for (j = 0; j < 4; j++)
                begin
                    if (ex[0])
                        prod_m[i][j] = next_prod[i][j];
                    base_m[i][j] = next_base[i][j];
                end
            end
            ex = ex >> 1;
        end
        // last row against seeds f(1..4)
        term = 0;
        for (i = 0; i < 4; i++)
            term += prod_m[3][i] * seeds[i + 1];
        term = term % TERM_MOD;
        return term[rtmp_pkg::TERM_VALUE_W-1:0];
    endfunction

    // wait before the next word on either side, none during a calm stretch
    function automatic int draw_gap(input bit calm);
        return calm ? 0 : $urandom_range(0, 9);
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic queue_index(input logic [rtmp_pkg::TERM_INDEX_W-1:0] idx, input bit drain);
        index_q.push_back('{index: idx, drain_first: drain});
    endtask

    // driver: one word per handshake, gap drawn after each accepted word
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            send_wait = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                term_expected_q.push_back('{
                    index: s_tdata[rtmp_pkg::TERM_INDEX_W-1:0],
                    value: term_mod_of(s_tdata[rtmp_pkg::TERM_INDEX_W-1:0])});
                words_sent++;
                if (s_tdata[rtmp_pkg::TERM_INDEX_W-1:0] <= rtmp_pkg::SEED_LAST)
                    seed_words++;
                if (s_tdata[rtmp_pkg::TERM_INDEX_W-1:0] >= (1 << 24))
                    wide_words++;
                send_wait = draw_gap(send_calm);
                if ($urandom_range(0, 11) == 0)
                    send_calm = !send_calm;
            end
            // a word not yet taken stays on the bus unchanged
            if (!(s_tvalid && !s_tready))
            begin
                if (send_wait > 0)
                begin
                    send_wait--;
                    s_tvalid <= 1'b0;
                end
                else if (index_q.size() != 0 &&
                         !(index_q[0].drain_first && term_expected_q.size() != 0))
                begin
                    next_item = index_q.pop_front();
                    s_tdata  <= {{(rtmp_pkg::S_TDATA_W-rtmp_pkg::TERM_INDEX_W){1'b0}},
                                 next_item.index};
                    s_tvalid <= 1'b1;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each term word, then holds ready low for a drawn count
    // of cycles in which a word is waiting
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            take_wait = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (term_expected_q.size() == 0)
                begin
                    report_mismatch($sformatf("term word %0d with nothing pending",
                                              m_tdata[rtmp_pkg::TERM_VALUE_W-1:0]));
                end
                else
                begin
                    owed = term_expected_q.pop_front();
                    terms_checked++;
                    if (m_tdata[rtmp_pkg::TERM_VALUE_W-1:0] !== owed.value)
                        report_mismatch($sformatf("index %0d: term_value %0d, want %0d",
                                                  owed.index,
                                                  m_tdata[rtmp_pkg::TERM_VALUE_W-1:0],
                                                  owed.value));
                end
                take_wait = draw_gap(take_calm);
                if ($urandom_range(0, 11) == 0)
                    take_calm = !take_calm;
            end
            else if (m_tvalid && take_wait > 0)
            begin
                take_wait--;
            end
            m_tready <= (take_wait == 0);
        end
    end

    // stimulus and end of run
    initial
    begin
        int          n;
        logic [31:0] rnd_word;
        // seeds and the first few computed terms
        for (n = 0; n <= 9; n++)
            queue_index(n[rtmp_pkg::TERM_INDEX_W-1:0], 1'b0);
        // around the modulus, single high bits, alternating bits and the extremes
        queue_index(31'd2005, 1'b0);
        queue_index(31'd2009, 1'b0);
        queue_index(31'd1000, 1'b0);
        queue_index(31'd68, 1'b0);
        queue_index(31'h0010_0004, 1'b0);
        queue_index(31'h4000_0000, 1'b0);
        queue_index(31'h5555_5555, 1'b0);
        queue_index(31'h2AAA_AAAA, 1'b0);
        queue_index(31'h7FFF_FFFE, 1'b0);
        queue_index(31'h7FFF_FFFF, 1'b0);
        // random part: short indices most often, some 16 bit, some full width
        for (n = 0; n < RAND_WORDS; n++)
        begin
            rnd_word = $urandom();
            case ($urandom_range(0, 9))
                0, 1, 2, 3: rnd_word = $urandom_range(0, 200);
                4, 5, 6:    rnd_word = rnd_word & 32'h0000_FFFF;
                default:    rnd_word = rnd_word & 32'h7FFF_FFFF;
            endcase
            // sender holds off until every term is back, after the directed
            // part and once in the middle
            queue_index(rnd_word[rtmp_pkg::TERM_INDEX_W-1:0],
                        (n == 0) || (n == RAND_WORDS / 2));
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (index_q.size() != 0 || s_tvalid || term_expected_q.size() != 0)
            @(negedge clk);
        repeat (TAIL_WAIT) @(posedge clk);

        $display("sent %0d indices (%0d seed cases, %0d above 2^24), checked %0d terms",
                 words_sent, seed_words, wide_words, terms_checked);
        $display("%0d mismatches", mismatch_count);
        if (mismatch_count == 0)
            $display("recurrence_term_matrix_power_mod verification clean");
        else
            $display("recurrence_term_matrix_power_mod verification failed");
        $finish;
    end

    // about 140 words at the worst case each still finish under 8 ms; allow 40 ms
    initial
    begin
        #40_000_000;
        $display("timeout: %0d terms still pending", term_expected_q.size());
        $display("recurrence_term_matrix_power_mod verification failed");
        $finish;
    end

endmodule

`default_nettype wire

/* recurrence_term_matrix_power_mod.f */
+incdir+hdl
hdl/rtmp_pkg.sv
hdl/rtmp_dpath.sv
hdl/rtmp_ctrl.sv
hdl/recurrence_term_matrix_power_mod.sv
hdl/rtmp_chk.sv
tb/recurrence_term_matrix_power_mod_tb.sv
